// File: rtl/dwr_pkg.sv
// Package for the deque with reverse flag: sizes, operation and status codes, ring wrap.
// Used by deque_with_reverse_top, which hands its sizes to dwr_ram through parameters.
package dwr_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int SW         = AW + 1;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Reduce a sum of two in-range ring positions back into the ring.
  function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[AW-1:0];
  endfunction

endpackage

// File: rtl/dwr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/deque_with_reverse_top.sv
// Deque of signed values in a ring buffer held in one RAM, with reverse flag.
// Depends on dwr_pkg and dwr_ram.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  command  | start & !busy        | in_op[2:0], in_value[31:0]
//  result   | out_valid (1 cycle)  | out_status[1:0], out_value_res[31:0]
//
// One command per cycle; busy stays low. A pop or a rejected push shows its
// result in the cycle after acceptance; the pop data comes straight from the
// RAM read register, issued at the accept edge. Pushes and reverse give no
// result. Reset (rst_n low, synchronous) empties the queue; the slot RAM is
// not cleared. The receiver cannot stall.
module deque_with_reverse_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_op,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_value_res
);
  import dwr_pkg::*;

  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  rev_r, rev_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic                  pop_ok_r, pop_ok_nxt;

  logic                  accept;
  logic                  full, empty;
  logic [AW-1:0]         head_m1, head_p1, tail_pos, last_pos;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  assign head_m1  = (head_r == '0) ? AW'(DEPTH - 1) : (head_r - AW'(1));
  assign head_p1  = ring_wrap(SW'(head_r) + SW'(1));
  assign tail_pos = ring_wrap(SW'(head_r) + SW'(count_r));
  // only used when the queue holds something
  assign last_pos = ring_wrap(SW'(head_r) + SW'(count_r) - SW'(1));
  assign wdata    = DATA_WIDTH'(in_value);

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    out_valid_nxt = 1'b0;
    status_nxt    = ST_OK;
    pop_ok_nxt    = 1'b0;
    we            = 1'b0;
    waddr         = tail_pos;
    re            = 1'b0;
    raddr         = head_r;
    if (accept) begin
      case (in_op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (full) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
            // physical back for push back with flag clear, or push front with flag set
            if ((in_op == OP_PUSH_BACK) != rev_r) begin
              waddr = tail_pos;
            end else begin
              waddr    = head_m1;
              head_nxt = head_m1;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            re         = 1'b1;
            pop_ok_nxt = 1'b1;
            count_nxt  = count_r - CW'(1);
            if ((in_op == OP_POP_BACK) != rev_r) begin
              raddr = last_pos;
            end else begin
              raddr    = head_r;
              head_nxt = head_p1;
            end
          end
        end
        OP_REVERSE: begin
          rev_nxt = !rev_r;
        end
        default: begin
          // unused op codes: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pop_ok_r    <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
      pop_ok_r    <= pop_ok_nxt;
      status_r    <= status_nxt;
    end
  end

  dwr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value_res = pop_ok_r ? 32'($signed(rdata)) : 32'sd0;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("item count above capacity");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < AW'(DEPTH - 1) || head_r == AW'(DEPTH - 1))
    else $error("head index outside ring");

  a_ok_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_POP_FRONT || in_op == OP_POP_BACK) && !empty)
    |=> (out_valid && out_status == ST_OK && count_r == $past(count_r) - CW'(1)))
    else $error("pop transaction did not return a value");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_PUSH_BACK || in_op == OP_PUSH_FRONT) && !full)
    |=> (!out_valid && count_r == $past(count_r) + CW'(1)))
    else $error("push transaction did not store");

  a_no_write_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    re |-> !we)
    else $error("RAM read and write in one transaction");
`endif

endmodule
